>>> sv/wss_pkg.sv
`timescale 1ns / 1ps

package wss_pkg;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_BYTES    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HAYSTACK_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_POS       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LENGTH    = 3'd4;

   // Fixed field widths
   localparam int CSR_DATA_BITS   = 64;
   localparam int NEEDLE_LEN_BITS = 4;
   localparam int HAY_LEN_BITS    = 16;
   localparam int WIN_BITS        = 17;
   localparam int RESULT_POS_BITS = 16;

   // Search window in 0-based byte positions: [win_start, win_end)
   typedef struct packed {
      logic                err;
      logic [WIN_BITS-1:0] win_start;
      logic [WIN_BITS-1:0] win_end;
   } window_type;

endpackage

>>> sv/wss_window.sv
`timescale 1ns / 1ps

module wss_window
   import wss_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [CSR_DATA_BITS-1:0]   needle_bytes,
   output logic [NEEDLE_LEN_BITS-1:0] needle_length,
   output window_type                 window
);

   logic [CSR_DATA_BITS-1:0]   needle_ff, needle_in;
   logic [NEEDLE_LEN_BITS-1:0] nlen_ff, nlen_in;
   logic [HAY_LEN_BITS-1:0]    hay_ff, hay_in;
   logic [WIN_BITS-1:0]        start_ff, start_in;
   logic [WIN_BITS-1:0]        range_ff, range_in;
   window_type                 window_ff, window_in;

   // Next register values, so the window is ready alongside the registers
   always_comb begin
      needle_in = needle_ff;
      nlen_in   = nlen_ff;
      hay_in    = hay_ff;
      start_in  = start_ff;
      range_in  = range_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NEEDLE_BYTES:    needle_in = csr_wdata;
            CSR_NEEDLE_LENGTH:   nlen_in   = csr_wdata[NEEDLE_LEN_BITS-1:0];
            CSR_HAYSTACK_LENGTH: hay_in    = csr_wdata[HAY_LEN_BITS-1:0];
            CSR_START_POS:       start_in  = csr_wdata[WIN_BITS-1:0];
            CSR_RANGE_LENGTH:    range_in  = csr_wdata[WIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Window clipping, worked in 18-bit signed arithmetic
   always_comb begin
      logic signed [WIN_BITS:0] lenh;
      logic signed [WIN_BITS:0] b;
      logic signed [WIN_BITS:0] l;
      logic signed [WIN_BITS:0] e;
      lenh = signed'({2'b00, hay_in});
      b    = signed'({start_in[WIN_BITS-1], start_in});
      l    = signed'({range_in[WIN_BITS-1], range_in});
      window_in.err = 1'b0;
      if (l < 0) begin
         window_in.err = 1'b1;
         b = '0;
         l = '0;
      end else if (b == 0) begin
         if (l == 0 || l > lenh) begin
            l = lenh;
         end
      end else begin
         if (b > 0) begin
            b = b - 18'sd1;
         end else begin
            b = lenh + b;
         end
         if (b >= 0) begin
            if (l == 0) begin
               l = lenh;
            end
            if (b > lenh) begin
               l = '0;
            end else if (b + l > lenh) begin
               l = lenh - b;
            end
         end else if (l == 0) begin
            b = '0;
            l = lenh;
         end else if (b + l < 0) begin
            l = '0;
         end else begin
            l = l + b;
            b = '0;
         end
      end
      e = b + l;
      // A window wholly before the string comes out negative; clamp it empty
      window_in.win_start = (b < 0) ? '0 : b[WIN_BITS-1:0];
      window_in.win_end   = (e < 0) ? '0 : e[WIN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff <= '0;
         nlen_ff   <= '0;
         hay_ff    <= '0;
         start_ff  <= '0;
         range_ff  <= '0;
         window_ff <= '0;
      end else begin
         needle_ff <= needle_in;
         nlen_ff   <= nlen_in;
         hay_ff    <= hay_in;
         start_ff  <= start_in;
         range_ff  <= range_in;
         window_ff <= window_in;
      end
   end

   assign needle_bytes  = needle_ff;
   assign needle_length = nlen_ff;
   assign window        = window_ff;

endmodule

>>> sv/wss_matcher.sv
`timescale 1ns / 1ps

module wss_matcher
   import wss_pkg::*;
#(
   parameter int NEEDLE_MAX    = 8,
   parameter int POSITION_BITS = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 haystack_byte,
   input  logic                       last_byte,
   input  logic [CSR_DATA_BITS-1:0]   needle_bytes,
   input  logic [NEEDLE_LEN_BITS-1:0] needle_length,
   input  window_type                 window,
   output logic                       status,
   output logic [RESULT_POS_BITS-1:0] match_position
);

   localparam int CMP_BITS = (POSITION_BITS + 1 > WIN_BITS) ? POSITION_BITS + 1 : WIN_BITS;
   localparam logic [NEEDLE_LEN_BITS-1:0] NLEN_MAX = NEEDLE_LEN_BITS'(NEEDLE_MAX);

   logic [7:0]                 hist_ff [NEEDLE_MAX];
   logic [7:0]                 hist_in [NEEDLE_MAX];
   logic [POSITION_BITS-1:0]   index_ff, index_in;
   logic                       found_ff, found_in;
   logic [RESULT_POS_BITS-1:0] fpos_ff, fpos_in;

   logic [NEEDLE_LEN_BITS-1:0] n;
   logic [NEEDLE_MAX-1:0]      eq_len;
   logic                       eq;
   logic [CMP_BITS-1:0]        cnt;
   logic [CMP_BITS-1:0]        n_w;
   logic [CMP_BITS-1:0]        cand_pos;
   logic                       hit;

   assign n = (needle_length > NLEN_MAX) ? NLEN_MAX : needle_length;

   // History after shifting in the current byte
   always_comb begin
      hist_in[0] = haystack_byte;
      for (int k = 1; k < NEEDLE_MAX; k++) begin
         hist_in[k] = hist_ff[k-1];
      end
   end

   // Every needle length is compared against the bytes ending here
   always_comb begin
      for (int len = 1; len <= NEEDLE_MAX; len++) begin
         eq_len[len-1] = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (hist_in[len-1-j] != needle_bytes[8*j +: 8]) begin
               eq_len[len-1] = 1'b0;
            end
         end
      end
      eq = 1'b0;
      for (int len = 1; len <= NEEDLE_MAX; len++) begin
         if (n == NEEDLE_LEN_BITS'(len)) begin
            eq = eq_len[len-1];
         end
      end
   end

   // Window test on the alignment that ends on this byte
   assign cnt      = CMP_BITS'(index_ff) + CMP_BITS'(1);
   assign n_w      = CMP_BITS'(n);
   assign cand_pos = cnt - n_w + CMP_BITS'(1);
   assign hit = !window.err && !found_ff && (n != '0) && (cnt >= n_w)
              && (cnt >= CMP_BITS'(window.win_start) + n_w)
              && (cnt <= CMP_BITS'(window.win_end)) && eq;

   // Result of the string ending with this byte
   assign status = window.err;
   always_comb begin
      if (window.err) begin
         match_position = '0;
      end else if (found_ff) begin
         match_position = fpos_ff;
      end else if (hit) begin
         match_position = cand_pos[RESULT_POS_BITS-1:0];
      end else begin
         match_position = '0;
      end
   end

   // Per-string state: cleared after the last byte
   always_comb begin
      index_in = index_ff;
      found_in = found_ff;
      fpos_in  = fpos_ff;
      if (step) begin
         if (last_byte) begin
            index_in = '0;
            found_in = 1'b0;
            fpos_in  = '0;
         end else begin
            if (index_ff != '1) begin
               index_in = index_ff + POSITION_BITS'(1);
            end
            if (hit) begin
               found_in = 1'b1;
               fpos_in  = cand_pos[RESULT_POS_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int k = 0; k < NEEDLE_MAX; k++) begin
            hist_ff[k] <= last_byte ? 8'h00 : hist_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         found_ff <= 1'b0;
         fpos_ff  <= '0;
      end else begin
         index_ff <= index_in;
         found_ff <= found_in;
         fpos_ff  <= fpos_in;
      end
   end

   // A recorded match is never reported for a rejected window
   assert property (@(posedge clock) disable iff (reset)
      window.err |-> (match_position == '0))
      else $error("match position reported with error status");

   // A match is recorded only once per string
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> !hit)
      else $error("second match recorded in one string");

   // Positions are 1-based, so a recorded match is never at zero
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (fpos_ff != '0))
      else $error("match recorded at position zero");

endmodule

>>> sv/windowed_substring_search.sv
`timescale 1ns / 1ps

// Windowed first-occurrence substring search. Haystack bytes stream in on the
// req_ channel, one transaction per byte, with req_tlast on the final byte.
// Each byte is shifted into a history of NEEDLE_MAX bytes and every needle
// alignment ending on it is compared in parallel, so overlapping candidates
// are never missed. One byte is accepted per clock cycle unless stalled;
// each byte waits in the input register, and the result for a string is
// loaded into the result register when its last byte leaves the input
// register, which raises rsp_tvalid. The only stall comes from a result still
// waiting in the result register when the next last byte is in the input
// register. The window and needle are taken from the csr_ registers, which
// the user must write only between strings; the block does not enforce this.
// The window is recomputed as the registers are written. match_position is
// 1-based, 0 when there is no match, an empty window or an empty needle;
// rsp_tuser is set when range_length is negative.

module windowed_substring_search
   import wss_pkg::*;
#(
   parameter int NEEDLE_MAX    = 8,
   parameter int POSITION_BITS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   // Configuration port
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // Haystack stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] haystack_byte
   input  logic                      req_tlast,   // last_byte
   // Results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [15:0] match_position
   output logic                      rsp_tuser    // status
);

   logic [CSR_DATA_BITS-1:0]   needle_bytes;
   logic [NEEDLE_LEN_BITS-1:0] needle_length;
   window_type                 window;

   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_byte_ff, in_byte_in;
   logic                       in_last_ff, in_last_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_status_ff, out_status_in;
   logic [RESULT_POS_BITS-1:0] out_pos_ff, out_pos_in;

   logic                       out_free;
   logic                       advance;
   logic                       res_status;
   logic [RESULT_POS_BITS-1:0] res_pos;

   wss_window u_window (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .needle_bytes  (needle_bytes),
      .needle_length (needle_length),
      .window        (window)
   );

   wss_matcher #(
      .NEEDLE_MAX    (NEEDLE_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_matcher (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .haystack_byte  (in_byte_ff),
      .last_byte      (in_last_ff),
      .needle_bytes   (needle_bytes),
      .needle_length  (needle_length),
      .window         (window),
      .status         (res_status),
      .match_position (res_pos)
   );

   // Only a last byte needs room in the result register
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_pos_in    = out_pos_ff;
      if (advance && in_last_ff) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status;
         out_pos_in    = res_pos;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      out_status_ff <= out_status_in;
      out_pos_ff    <= out_pos_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pos_ff;
   assign rsp_tuser  = out_status_ff;

   // A last byte leaving the input register always produces a result
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> out_valid_ff)
      else $error("result lost after last byte");

   // Back-pressure upstream only while the input register is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && out_valid_ff))
      else $error("input stalled without cause");

   // An error result carries no position
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff) |-> (out_pos_ff == '0))
      else $error("error result with non-zero position");

endmodule
